FILE: src/hll_pkg.sv
package hll_pkg;

	typedef enum logic [1:0] {
		CMD_ADD      = 2'd0,
		CMD_MERGE    = 2'd1,
		CMD_ESTIMATE = 2'd2
	} cmd_t;

	localparam int unsigned HASH_W  = 64;
	localparam int unsigned MIDX_W  = 10;
	localparam int unsigned RANK_W  = 6;
	localparam int unsigned EST_W   = 64;
	localparam int unsigned EMPTY_W = 11;
	localparam int unsigned FRAC_W  = 32;

	// ln(2) in q28
	localparam logic [27:0] LN2_Q28 = 28'd186065280;

endpackage

FILE: src/hll_req_if.sv
interface hll_req_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        command;
	logic [hll_pkg::HASH_W-1:0]        hash;
	logic [hll_pkg::MIDX_W-1:0]        merge_index;
	logic [hll_pkg::RANK_W-1:0]        merge_value;

	modport source (output valid, command, hash, merge_index, merge_value, input ready);
	modport sink (input valid, command, hash, merge_index, merge_value, output ready);
endinterface

FILE: src/hll_rsp_if.sv
interface hll_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [hll_pkg::EST_W-1:0]         distinct_estimate;
	logic [hll_pkg::EMPTY_W-1:0]       empty_registers;
	logic                              small_range_used;

	modport source (output valid, distinct_estimate, empty_registers, small_range_used,
		input ready);
	modport sink (input valid, distinct_estimate, empty_registers, small_range_used,
		output ready);
endinterface

FILE: src/hyperloglog_distinct_counter_top.sv
// add and merge: one read-modify-write on the rank memory per request
// estimate: walk of 2^INDEX_BITS memory reads, a restoring divide for the 64-bit quotient, and when
// linear counting applies log2 by repeated squaring for 32 fraction bits (one 32x32 multiply per step)
// unknown commands are accepted and dropped with no response; one request is in work at a time
// reset clears control state, then a clearing pass over all 2^INDEX_BITS entries zeroes
// the rank memory while no request is taken
module hyperloglog_distinct_counter_top #(
	parameter int unsigned INDEX_BITS = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	hll_req_if.sink   req,
	hll_rsp_if.source rsp
);
	localparam int unsigned P     = INDEX_BITS;
	localparam int unsigned W     = 64 - P;
	localparam int unsigned ZW    = P + 1;
	localparam int unsigned SUM_W = 33 + P;
	localparam int unsigned CW    = (ZW > 11) ? ZW : 11;
	localparam logic [63:0] M     = 64'd1 << P;
	localparam logic [63:0] ALPHA = ((64'd7213 * M) << 32) / (64'd10 * (64'd1000 * M + 64'd1079));
	localparam logic [63:0] NUM   = ALPHA << (2 * P);
	localparam logic [63:0] LIM   = (64'd5 * M) / 64'd2;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_RMW, ST_WALK, ST_DRAIN, ST_DIVST, ST_DIV,
		ST_LOGI, ST_SQ, ST_NORM, ST_LN, ST_SCALE, ST_DONE
	} state_t;

	state_t           state_q;
	logic [P-1:0]     cnt_q;
	logic [P-1:0]     idx_q;
	logic [5:0]       rank_q;
	logic             walk_s1;
	logic [5:0]       rd_q;
	logic [SUM_W-1:0] sum_q;
	logic [ZW-1:0]    zeros_q;
	logic [63:0]      est_q;
	logic             small_q;
	logic [31:0]      y_q;
	logic [63:0]      prod_q;
	logic [4:0]       k_q;
	logic [31:0]      frac_q;
	logic [4:0]       bit_q;
	logic [36:0]      g_q;
	logic             rsp_valid_q;
	logic [63:0]      rsp_est_q;
	logic [10:0]      rsp_empty_q;
	logic             rsp_small_q;

	logic [5:0] mem [1 << P];

	logic [P-1:0]  midx;
	logic [W-1:0]  rest;
	logic [5:0]    rank_c;
	logic [P-1:0]  rd_addr;
	logic          wr_en;
	logic [P-1:0]  wr_addr;
	logic [5:0]    wr_data;
	logic          div_start;
	logic          div_done;
	logic [63:0]   div_q;
	logic [SUM_W-1:0] div_r;
	logic [4:0]    k_c;
	logic [32:0]   sq_t;
	logic [36:0]   d_c;
	logic [64:0]   ln_p;
	logic [CW-1:0] z_w;
	logic          accept;
	logic          small_c;

	always_comb begin
		midx = P'({{P{1'b0}}, req.merge_index});
		rest = req.hash[63:P];
		rank_c = 6'(W + 1);
		for (int i = 0; i < W; i++) begin
			if (rest[i]) begin
				rank_c = 6'(W - i);
			end
		end
		k_c = '0;
		for (int i = 0; i < ZW; i++) begin
			if (zeros_q[i]) begin
				k_c = 5'(i);
			end
		end
		accept  = req.valid && req.ready;
		rd_addr = (state_q == ST_WALK) ? cnt_q :
			(req.command == hll_pkg::CMD_MERGE) ? midx : req.hash[P-1:0];
		wr_en   = (state_q == ST_CLEAR) || ((state_q == ST_RMW) && (rank_q > rd_q));
		wr_addr = (state_q == ST_CLEAR) ? cnt_q : idx_q;
		wr_data = (state_q == ST_CLEAR) ? 6'd0 : rank_q;
		div_start = (state_q == ST_DIVST) && (sum_q != '0);
		small_c = ((div_q < LIM) || ((div_q == LIM) && (div_r == '0))) && (zeros_q != '0);
		sq_t = prod_q[63:31];
		d_c  = (37'(P) << 32) - {k_q, frac_q};
		ln_p = 65'(d_c) * 65'(hll_pkg::LN2_Q28);
		z_w  = CW'(zeros_q);
	end

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	hll_div #(.NW(64), .DW(SUM_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (NUM),
		.divisor   (sum_q),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			walk_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			walk_s1 <= (state_q == ST_WALK);
			if (rsp_valid_q && rsp.ready && (state_q != ST_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			if (walk_s1) begin
				if (rd_q == 6'd0) begin
					zeros_q <= zeros_q + 1'b1;
				end
				if (rd_q <= 6'd32) begin
					sum_q <= sum_q + (SUM_W'(1) << (6'd32 - rd_q));
				end
			end
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (hll_pkg::cmd_t'(req.command))
							hll_pkg::CMD_ADD: begin
								idx_q   <= req.hash[P-1:0];
								rank_q  <= rank_c;
								state_q <= ST_RMW;
							end
							hll_pkg::CMD_MERGE: begin
								idx_q   <= midx;
								rank_q  <= req.merge_value;
								state_q <= ST_RMW;
							end
							hll_pkg::CMD_ESTIMATE: begin
								cnt_q   <= '0;
								sum_q   <= '0;
								zeros_q <= '0;
								state_q <= ST_WALK;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RMW: begin
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DIVST;
				end
				ST_DIVST: begin
					if (sum_q == '0) begin
						est_q   <= '1;
						small_q <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						est_q   <= div_q;
						small_q <= small_c;
						state_q <= small_c ? ST_LOGI : ST_DONE;
					end
				end
				ST_LOGI: begin
					y_q     <= 32'({{(32 - ZW){1'b0}}, zeros_q} << (5'd31 - k_c));
					k_q     <= k_c;
					frac_q  <= '0;
					bit_q   <= 5'd31;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					prod_q  <= 64'(y_q) * 64'(y_q);
					state_q <= ST_NORM;
				end
				ST_NORM: begin
					if (sq_t[32]) begin
						y_q           <= sq_t[32:1];
						frac_q[bit_q] <= 1'b1;
					end else begin
						y_q <= sq_t[31:0];
					end
					if (bit_q == '0) begin
						state_q <= ST_LN;
					end else begin
						bit_q   <= bit_q - 1'b1;
						state_q <= ST_SQ;
					end
				end
				ST_LN: begin
					g_q     <= ln_p[64:28];
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					est_q   <= 64'({g_q, {P{1'b0}}} >> 32);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_est_q   <= est_q;
						rsp_empty_q <= (z_w > CW'(2047)) ? 11'd2047 : z_w[10:0];
						rsp_small_q <= small_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.distinct_estimate = rsp_est_q;
	assign rsp.empty_registers   = rsp_empty_q;
	assign rsp.small_range_used  = rsp_small_q;

	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK || state_q == ST_DRAIN) |-> !wr_en)
		else $error("rank memory written during estimate walk");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside divide state");

	a_small_has_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.small_range_used) |-> (rsp.empty_registers != '0))
		else $error("linear counting reported with no empty registers");
endmodule

FILE: src/hll_div.sv
module hll_div #(
	parameter int unsigned NW = 64,
	parameter int unsigned DW = 49
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient,
	output logic [DW-1:0] remainder
);
	localparam int unsigned CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [NW-1:0] quot_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   sh;
	logic [DW+1:0] diff;
	logic          ge;

	always_comb begin
		sh   = {rem_q, quot_q[NW-1]};
		diff = {1'b0, sh} - {2'b00, divisor};
		ge   = ~diff[DW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (cnt_q != '0) begin
			quot_q <= {quot_q[NW-2:0], ge};
			rem_q  <= ge ? diff[DW-1:0] : sh[DW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quot_q;
	assign remainder = rem_q;
endmodule

FILE: verif/hll_scoreboard.sv
`timescale 1ns / 1ps

module hll_scoreboard (
	input  logic clk,
	input  logic arst_n,
	hll_req_if   req,
	hll_rsp_if   rsp,
	output int   errors,
	output int   pending
);
	localparam int unsigned NREG = 1 << 10;
	localparam logic [63:0] LN2_FIX = 64'd186065280;

	typedef struct packed {
		logic [hll_pkg::EST_W-1:0]   est;
		logic [hll_pkg::EMPTY_W-1:0] empty;
		logic                        lin;
	} estimate_t;

	logic [hll_pkg::RANK_W-1:0] ranks [NREG];
	estimate_t                  estimates_due[$];

	function automatic logic [hll_pkg::RANK_W-1:0] hash_rank(logic [63:0] h);
		logic [63:0] rest;
		int          top;
		rest = h >> 10;
		top = 0;
		if (rest == 0)
			return hll_pkg::RANK_W'(64 - 10 + 1);
		while (rest > 1) begin
			rest = rest >> 1;
			top++;
		end
		return hll_pkg::RANK_W'(64 - 10 - top);
	endfunction

	function automatic logic [63:0] log2_fix(logic [63:0] z);
		int          k;
		logic [63:0] t;
		logic [63:0] y;
		logic [63:0] res;
		k = 0;
		t = z;
		while (t > 1) begin
			t = t >> 1;
			k++;
		end
		y = z << (31 - k);
		res = 64'(k) << 32;
		for (int i = 31; i >= 0; i--) begin
			y = (y * y) >> 31;
			if (y >= (64'd1 << 32)) begin
				y = y >> 1;
				res[i] = 1'b1;
			end
		end
		return res;
	endfunction

	function automatic estimate_t cardinality();
		logic [63:0] sum;
		logic [63:0] zeros;
		logic [63:0] m;
		logic [63:0] alpha;
		logic [63:0] num;
		logic [63:0] lim;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] d;
		logic [63:0] g;
		estimate_t   e;
		sum = 0;
		zeros = 0;
		m = NREG;
		for (int i = 0; i < NREG; i++) begin
			if (ranks[i] == 0)
				zeros++;
			if (ranks[i] <= 32)
				sum += 64'd1 << (32 - ranks[i]);
		end
		alpha = ((64'd7213 * m) << 32) / (64'd10 * (64'd1000 * m + 64'd1079));
		num = alpha * m * m;
		lim = (64'd5 * m) / 2;
		e.lin = 1'b0;
		if (sum == 0) begin
			e.est = '1;
		end else begin
			q = num / sum;
			rem = num % sum;
			e.est = q;
			if ((q < lim || (q == lim && rem == 0)) && zeros > 0) begin
				d = (64'd10 << 32) - log2_fix(zeros);
				g = (d * LN2_FIX) >> 28;
				e.est = (m * g) >> 32;
				e.lin = 1'b1;
			end
		end
		e.empty = zeros > 2047 ? 11'd2047 : hll_pkg::EMPTY_W'(zeros);
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		estimate_t got;
		estimate_t want;
		int        bad;
		bad = 0;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
			for (int i = 0; i < NREG; i++)
				ranks[i] = '0;
			estimates_due.delete();
		end else begin
			if (req.valid && req.ready) begin
				case (req.command)
					hll_pkg::CMD_ADD: begin
						if (hash_rank(req.hash) > ranks[req.hash[9:0]])
							ranks[req.hash[9:0]] = hash_rank(req.hash);
					end
					hll_pkg::CMD_MERGE: begin
						if (req.merge_value > ranks[req.merge_index])
							ranks[req.merge_index] = req.merge_value;
					end
					hll_pkg::CMD_ESTIMATE: begin
						estimates_due = {estimates_due, cardinality()};
					end
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				got.est = rsp.distinct_estimate;
				got.empty = rsp.empty_registers;
				got.lin = rsp.small_range_used;
				if (estimates_due.size() == 0) begin
					$display("%0t: unexpected result est=%0d empty=%0d lin=%0d",
						$time, got.est, got.empty, got.lin);
					bad++;
				end else begin
					want = estimates_due.pop_front();
					if (got.est !== want.est) begin
						$display("%0t: distinct_estimate expected %0d actual %0d",
							$time, want.est, got.est);
						bad++;
					end
					if (got.empty !== want.empty) begin
						$display("%0t: empty_registers expected %0d actual %0d",
							$time, want.empty, got.empty);
						bad++;
					end
					if (got.lin !== want.lin) begin
						$display("%0t: small_range_used expected %0d actual %0d",
							$time, want.lin, got.lin);
						bad++;
					end
				end
			end
			errors <= errors + bad;
			pending <= estimates_due.size();
		end
	end
endmodule

FILE: verif/hyperloglog_distinct_counter_top_test.sv
`timescale 1ns / 1ps

module hyperloglog_distinct_counter_top_test;
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   send_idle;
	int   recv_stall;
	int   quiet_cycles;

	hll_req_if req_ch ();
	hll_rsp_if rsp_ch ();

	hyperloglog_distinct_counter_top #(.INDEX_BITS(10)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	hll_scoreboard i_scoreboard (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("hyperloglog_distinct_counter_top: mismatch");
			$finish;
		end
	end

	task automatic send(logic [1:0] cmd, logic [63:0] h, logic [9:0] idx, logic [5:0] val);
		while ($urandom_range(0, 99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.hash <= h;
		req_ch.merge_index <= idx;
		req_ch.merge_value <= val;
		@(negedge clk);
		while (!req_ch.ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_random();
		int          pick;
		logic [63:0] h;
		pick = $urandom_range(0, 99);
		h = {$urandom, $urandom} >> $urandom_range(0, 54);
		h = (h << 10) | 64'($urandom_range(0, 1023));
		if (pick < 70)
			send(hll_pkg::CMD_ADD, h, 10'($urandom), 6'($urandom));
		else if (pick < 88)
			send(hll_pkg::CMD_MERGE, h, 10'($urandom), 6'($urandom));
		else if (pick < 96)
			send(hll_pkg::CMD_ESTIMATE, h, 10'($urandom), 6'($urandom));
		else
			send(CMD_NONE, h, 10'($urandom), 6'($urandom));
	endtask

	task automatic idle_sender_until_done();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int modes_send[4];
		int modes_recv[4];
		modes_send = '{0, 69, 0, 33};
		modes_recv = '{0, 0, 69, 33};
		send_idle = 0;
		recv_stall = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = hll_pkg::CMD_ADD;
		req_ch.hash = '0;
		req_ch.merge_index = '0;
		req_ch.merge_value = '0;
		rsp_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send(hll_pkg::CMD_ESTIMATE, '0, '0, '0);
		send(hll_pkg::CMD_ADD, 64'd0, '0, '0);
		send(hll_pkg::CMD_ADD, '1, '0, '0);
		send(hll_pkg::CMD_ADD, 64'h0000_0000_0000_07ff, '0, '0);
		send(hll_pkg::CMD_ADD, 64'h8000_0000_0000_0005, '0, '0);
		send(hll_pkg::CMD_ADD, 64'h0000_0000_0001_0006, '0, '0);
		send(hll_pkg::CMD_MERGE, '1, 10'h3ff, 6'h3f);
		send(hll_pkg::CMD_MERGE, '0, 10'h000, 6'h00);
		send(hll_pkg::CMD_MERGE, '0, 10'h155, 6'h2a);
		send(hll_pkg::CMD_MERGE, '0, 10'h2aa, 6'h15);
		send(CMD_NONE, '1, '1, '1);
		send(hll_pkg::CMD_ESTIMATE, '0, '0, '0);
		send(hll_pkg::CMD_ADD, 64'h0000_0000_0000_0409, '0, '0);
		send(hll_pkg::CMD_ESTIMATE, '1, '1, '1);

		for (int phase = 0; phase < 4; phase++) begin
			send_idle = modes_send[phase];
			recv_stall = modes_recv[phase];
			for (int n = 0; n < 100; n++)
				send_random();
			idle_sender_until_done();
		end

		// push every rank beyond the sum range
		send_idle = 0;
		recv_stall = 0;
		for (int i = 0; i < 1024; i++) begin
			send(hll_pkg::CMD_MERGE, {$urandom, $urandom}, 10'(i),
				6'($urandom_range(33, 63)));
			if (i % 256 == 255)
				send(hll_pkg::CMD_ESTIMATE, '0, '0, '0);
		end
		send_random();
		send(hll_pkg::CMD_ESTIMATE, '0, '0, '0);

		idle_sender_until_done();
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("hyperloglog_distinct_counter_top: match");
		end else begin
			$display("hyperloglog_distinct_counter_top: mismatch");
		end
		$finish;
	end
endmodule
